// ----- rtl/sssp_pkg.sv -----
// Shared types and constants for the single-source shortest path block.
// No dependencies; the top, the relaxation unit and the testbench use this package by scoped names.
package sssp_pkg;

  localparam int VIDX_W    = 4;
  localparam int WEIGHT_W  = 16;
  localparam int DIST_W    = 21;
  localparam int VCOUNT_W  = 5;
  localparam int VMAX_IDX  = 16;
  localparam int DIST_MAX  = 1048575;
  localparam int DIST_MIN  = -1048576;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic [VIDX_W-1:0]          src;
    logic [VIDX_W-1:0]          dst;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD_EDGE,
    S_RD_SRC,
    S_RD_DST,
    S_RELAX,
    S_OUT_RD,
    S_OUT_LD,
    S_NEG
  } state_t;

endpackage

// ----- rtl/single_source_shortest_path_top.sv -----
// Top level of the single-source shortest path block: sequencer and tables.
// Depends on sssp_pkg, sssp_ram and sssp_relax.
//
//  channel  | handshake          | words
//  ---------+--------------------+--------------------------------------------
//  input    | start & !busy      | in_req_type, in_edge_from/to/weight
//  result   | out_strobe         | out_vertex_index ... out_last
//  config   | cfg_wr_en          | cfg_wr_data (vertex count)
//
// Edge loads may follow each other every cycle while the block is not busy.
// A start runs N + 1 passes over the E stored edges, N being the active vertex count,
// the last pass only checking for a negative cycle; it then gives one result word per
// vertex (read from the single-read-port vertex table, then registered), or one negative-cycle word.
// Reset is synchronous and active low; it empties the edge store and sets N to one.
// Result words appear for one cycle each and are never held back.
module single_source_shortest_path_top #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_EDGES    = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_req_type,
  input  logic [sssp_pkg::VIDX_W-1:0]           in_edge_from,
  input  logic [sssp_pkg::VIDX_W-1:0]           in_edge_to,
  input  logic signed [sssp_pkg::WEIGHT_W-1:0]  in_edge_weight,
  input  logic                                  cfg_wr_en,
  input  logic [sssp_pkg::VCOUNT_W-1:0]         cfg_wr_data,
  output logic                                  out_strobe,
  output logic [sssp_pkg::VIDX_W-1:0]           out_vertex_index,
  output logic signed [sssp_pkg::DIST_W-1:0]    out_distance,
  output logic [sssp_pkg::VIDX_W-1:0]           out_predecessor,
  output logic                                  out_reachable,
  output logic                                  out_negative_cycle,
  output logic                                  out_last
);

  localparam int VT_DEPTH = (MAX_VERTICES < sssp_pkg::VMAX_IDX) ? MAX_VERTICES
                                                               : sssp_pkg::VMAX_IDX;
  localparam int VAW      = $clog2(VT_DEPTH);
  localparam int EAW      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W    = $clog2(MAX_EDGES + 1);
  localparam int ACC_W    = $clog2(16 * MAX_EDGES + 2) + sssp_pkg::WEIGHT_W + 1;
  localparam int VT_W     = sssp_pkg::VIDX_W + ACC_W;
  localparam int VC_W     = sssp_pkg::VCOUNT_W;
  localparam int VI_W     = sssp_pkg::VIDX_W;
  localparam int NV       = sssp_pkg::VMAX_IDX;

  localparam logic [VC_W-1:0]         N_LIMIT  = VC_W'(VT_DEPTH);
  localparam logic [CNT_W-1:0]        CNT_FULL = CNT_W'(MAX_EDGES);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(sssp_pkg::DIST_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(sssp_pkg::DIST_MIN);

  sssp_pkg::state_t state_r, state_nxt;

  logic [VC_W-1:0]                  vertex_count_r, vertex_count_nxt;
  logic [VC_W-1:0]                  n_r, n_nxt;
  logic [VC_W-1:0]                  pass_r, pass_nxt;
  logic [CNT_W-1:0]                 edge_count_r, edge_count_nxt;
  logic [EAW-1:0]                   j_r, j_nxt;
  logic [VI_W-1:0]                  v_r, v_nxt;
  logic [NV-1:0]                    reach_r, reach_nxt;
  logic                             neg_r, neg_nxt;
  sssp_pkg::edge_t                  edge_r, edge_nxt;
  logic signed [ACC_W-1:0]          dsrc_r, dsrc_nxt;

  logic                             strobe_r, strobe_nxt;
  logic [VI_W-1:0]                  oidx_r, oidx_nxt;
  logic signed [sssp_pkg::DIST_W-1:0] odist_r, odist_nxt;
  logic [VI_W-1:0]                  opred_r, opred_nxt;
  logic                             oreach_r, oreach_nxt;
  logic                             oneg_r, oneg_nxt;
  logic                             olast_r, olast_nxt;

  logic                             accept;
  logic                             edge_we;
  logic [EAW-1:0]                   edge_raddr;
  logic [sssp_pkg::EDGE_W-1:0]      edge_wdata;
  logic [sssp_pkg::EDGE_W-1:0]      edge_rdata;
  sssp_pkg::edge_t                  edge_rd;
  logic                             vt_we;
  logic [VAW-1:0]                   vt_waddr;
  logic [VT_W-1:0]                  vt_wdata;
  logic [VAW-1:0]                   vt_raddr;
  logic [VT_W-1:0]                  vt_rdata;
  logic signed [ACC_W-1:0]          vt_rdist;
  logic [VI_W-1:0]                  vt_rpred;
  logic signed [ACC_W-1:0]          dist_sum;
  logic                             relax;
  logic                             check_pass;
  logic                             last_edge;
  logic [VC_W-1:0]                  n_raw;
  logic signed [ACC_W-1:0]          sat_dist;

  assign accept     = start && !busy;
  assign busy       = (state_r != sssp_pkg::S_IDLE);
  assign edge_wdata = {in_edge_from, in_edge_to, in_edge_weight};
  assign edge_rd    = sssp_pkg::edge_t'(edge_rdata);
  assign vt_rdist   = vt_rdata[ACC_W-1:0];
  assign vt_rpred   = vt_rdata[VT_W-1:ACC_W];
  assign check_pass = (pass_r == n_r);
  assign last_edge  = ((CNT_W'(j_r) + CNT_W'(1)) == edge_count_r);

  sssp_ram #(
    .WIDTH (sssp_pkg::EDGE_W),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_count_r[EAW-1:0]),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  sssp_ram #(
    .WIDTH (VT_W),
    .DEPTH (VT_DEPTH)
  ) u_vertex_ram (
    .clk   (clk),
    .we    (vt_we),
    .waddr (vt_waddr),
    .wdata (vt_wdata),
    .raddr (vt_raddr),
    .rdata (vt_rdata)
  );

  sssp_relax #(
    .ACC_W (ACC_W)
  ) u_relax (
    .edge_in  (edge_r),
    .n_active (n_r),
    .reach    (reach_r),
    .dist_src (dsrc_r),
    .dist_dst (vt_rdist),
    .dist_sum (dist_sum),
    .relax    (relax)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sssp_pkg::S_IDLE: begin
        if (accept && (in_req_type == sssp_pkg::REQ_START)) begin
          state_nxt = sssp_pkg::S_INIT;
        end
      end
      sssp_pkg::S_INIT: begin
        state_nxt = (edge_count_r == '0) ? sssp_pkg::S_OUT_RD : sssp_pkg::S_RD_EDGE;
      end
      sssp_pkg::S_RD_EDGE: state_nxt = sssp_pkg::S_RD_SRC;
      sssp_pkg::S_RD_SRC:  state_nxt = sssp_pkg::S_RD_DST;
      sssp_pkg::S_RD_DST:  state_nxt = sssp_pkg::S_RELAX;
      sssp_pkg::S_RELAX: begin
        if (last_edge && check_pass) begin
          state_nxt = (neg_r || relax) ? sssp_pkg::S_NEG : sssp_pkg::S_OUT_RD;
        end else begin
          state_nxt = sssp_pkg::S_RD_EDGE;
        end
      end
      sssp_pkg::S_OUT_RD: state_nxt = sssp_pkg::S_OUT_LD;
      sssp_pkg::S_OUT_LD: begin
        state_nxt = ((VC_W'(v_r) + VC_W'(1)) == n_r) ? sssp_pkg::S_IDLE
                                                     : sssp_pkg::S_OUT_RD;
      end
      sssp_pkg::S_NEG: state_nxt = sssp_pkg::S_IDLE;
      default: state_nxt = sssp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    edge_we    = 1'b0;
    edge_raddr = j_r;
    vt_we      = 1'b0;
    vt_waddr   = edge_r.dst[VAW-1:0];
    vt_wdata   = {edge_r.src, dist_sum};
    vt_raddr   = v_r[VAW-1:0];
    case (state_r)
      sssp_pkg::S_IDLE: begin
        edge_we = accept && (in_req_type == sssp_pkg::REQ_LOAD) &&
                  (edge_count_r < CNT_FULL);
      end
      sssp_pkg::S_INIT: begin
        vt_we    = 1'b1;
        vt_waddr = '0;
        vt_wdata = '0;
      end
      sssp_pkg::S_RD_SRC: vt_raddr = edge_rd.src[VAW-1:0];
      sssp_pkg::S_RD_DST: vt_raddr = edge_r.dst[VAW-1:0];
      sssp_pkg::S_RELAX:  vt_we    = relax && !check_pass;
      default: begin
      end
    endcase
  end

  always_comb begin
    n_raw            = (vertex_count_r == '0) ? VC_W'(1) : vertex_count_r;
    vertex_count_nxt = cfg_wr_en ? cfg_wr_data : vertex_count_r;
    n_nxt            = n_r;
    pass_nxt         = pass_r;
    edge_count_nxt   = edge_count_r;
    j_nxt            = j_r;
    v_nxt            = v_r;
    reach_nxt        = reach_r;
    neg_nxt          = neg_r;
    edge_nxt         = edge_r;
    dsrc_nxt         = dsrc_r;
    strobe_nxt       = 1'b0;
    oidx_nxt         = oidx_r;
    odist_nxt        = odist_r;
    opred_nxt        = opred_r;
    oreach_nxt       = oreach_r;
    oneg_nxt         = oneg_r;
    olast_nxt        = olast_r;
    sat_dist         = vt_rdist;
    if (vt_rdist > SAT_HI) begin
      sat_dist = SAT_HI;
    end else if (vt_rdist < SAT_LO) begin
      sat_dist = SAT_LO;
    end
    case (state_r)
      sssp_pkg::S_IDLE: begin
        if (edge_we) begin
          edge_count_nxt = edge_count_r + CNT_W'(1);
        end
        n_nxt = (n_raw > N_LIMIT) ? N_LIMIT : n_raw;
      end
      sssp_pkg::S_INIT: begin
        reach_nxt = NV'(1);
        neg_nxt   = 1'b0;
        pass_nxt  = '0;
        j_nxt     = '0;
        v_nxt     = '0;
      end
      sssp_pkg::S_RD_SRC: edge_nxt = edge_rd;
      sssp_pkg::S_RD_DST: dsrc_nxt = vt_rdist;
      sssp_pkg::S_RELAX: begin
        if (relax) begin
          if (check_pass) begin
            neg_nxt = 1'b1;
          end else begin
            reach_nxt[edge_r.dst] = 1'b1;
          end
        end
        if (last_edge) begin
          j_nxt    = '0;
          pass_nxt = pass_r + VC_W'(1);
        end else begin
          j_nxt = j_r + EAW'(1);
        end
      end
      sssp_pkg::S_OUT_RD: edge_count_nxt = '0;
      sssp_pkg::S_OUT_LD: begin
        strobe_nxt = 1'b1;
        oidx_nxt   = v_r;
        oreach_nxt = reach_r[v_r];
        odist_nxt  = reach_r[v_r] ? sat_dist[sssp_pkg::DIST_W-1:0] : '0;
        opred_nxt  = reach_r[v_r] ? vt_rpred : '0;
        oneg_nxt   = 1'b0;
        olast_nxt  = ((VC_W'(v_r) + VC_W'(1)) == n_r);
        v_nxt      = v_r + VI_W'(1);
      end
      sssp_pkg::S_NEG: begin
        edge_count_nxt = '0;
        strobe_nxt     = 1'b1;
        oidx_nxt       = '0;
        odist_nxt      = '0;
        opred_nxt      = '0;
        oreach_nxt     = 1'b0;
        oneg_nxt       = 1'b1;
        olast_nxt      = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= sssp_pkg::S_IDLE;
      vertex_count_r <= VC_W'(1);
      edge_count_r   <= '0;
      reach_r        <= '0;
      neg_r          <= 1'b0;
      strobe_r       <= 1'b0;
      n_r            <= VC_W'(1);
      pass_r         <= '0;
      j_r            <= '0;
      v_r            <= '0;
    end else begin
      state_r        <= state_nxt;
      vertex_count_r <= vertex_count_nxt;
      edge_count_r   <= edge_count_nxt;
      reach_r        <= reach_nxt;
      neg_r          <= neg_nxt;
      strobe_r       <= strobe_nxt;
      n_r            <= n_nxt;
      pass_r         <= pass_nxt;
      j_r            <= j_nxt;
      v_r            <= v_nxt;
    end
    edge_r   <= edge_nxt;
    dsrc_r   <= dsrc_nxt;
    oidx_r   <= oidx_nxt;
    odist_r  <= odist_nxt;
    opred_r  <= opred_nxt;
    oreach_r <= oreach_nxt;
    oneg_r   <= oneg_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_strobe         = strobe_r;
  assign out_vertex_index   = oidx_r;
  assign out_distance       = odist_r;
  assign out_predecessor    = opred_r;
  assign out_reachable      = oreach_r;
  assign out_negative_cycle = oneg_r;
  assign out_last           = olast_r;

endmodule

// ----- rtl/sssp_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sssp_relax.sv -----
// Shared relaxation unit: one add and one signed compare per edge visit.
// Depends on sssp_pkg for the edge word layout.
module sssp_relax #(
  parameter int ACC_W = 27
) (
  input  sssp_pkg::edge_t                     edge_in,
  input  logic [sssp_pkg::VCOUNT_W-1:0]       n_active,
  input  logic [sssp_pkg::VMAX_IDX-1:0]       reach,
  input  logic signed [ACC_W-1:0]             dist_src,
  input  logic signed [ACC_W-1:0]             dist_dst,
  output logic signed [ACC_W-1:0]             dist_sum,
  output logic                                relax
);

  logic in_range;
  logic src_reach;
  logic dst_reach;

  always_comb begin
    in_range  = ({1'b0, edge_in.src} < n_active) && ({1'b0, edge_in.dst} < n_active);
    src_reach = reach[edge_in.src];
    dst_reach = reach[edge_in.dst];
    dist_sum  = dist_src + ACC_W'(edge_in.weight);
    relax     = in_range && src_reach && (!dst_reach || (dist_sum < dist_dst));
  end

endmodule

// ----- dv/single_source_shortest_path_top_tb.sv -----
// Self-checking testbench for single_source_shortest_path_top: edge loads, searches and
// vertex-count writes, with every result word checked against a local shortest-path solver.
// Depends on sssp_pkg and the RTL of the block; needs no files or arguments.
module single_source_shortest_path_top_tb;

  localparam int HALF_PERIOD    = 4;
  localparam int MAX_NODES      = 16;
  localparam int MAX_ARCS       = 64;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int ITEM_TARGET    = 170;

  typedef struct packed {
    logic [sssp_pkg::VIDX_W-1:0]        vertex;
    logic signed [sssp_pkg::DIST_W-1:0] span;
    logic [sssp_pkg::VIDX_W-1:0]        prev;
    logic                               reach;
    logic                               neg;
    logic                               last;
  } path_word_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic                                 in_req_type = sssp_pkg::REQ_LOAD;
  logic [sssp_pkg::VIDX_W-1:0]          in_edge_from = '0;
  logic [sssp_pkg::VIDX_W-1:0]          in_edge_to = '0;
  logic signed [sssp_pkg::WEIGHT_W-1:0] in_edge_weight = '0;
  logic                                 cfg_wr_en = 1'b0;
  logic [sssp_pkg::VCOUNT_W-1:0]        cfg_wr_data = '0;
  logic                                 out_strobe;
  logic [sssp_pkg::VIDX_W-1:0]          out_vertex_index;
  logic signed [sssp_pkg::DIST_W-1:0]   out_distance;
  logic [sssp_pkg::VIDX_W-1:0]          out_predecessor;
  logic                                 out_reachable;
  logic                                 out_negative_cycle;
  logic                                 out_last;

  sssp_pkg::edge_t               arc_store [MAX_ARCS];
  int                            arcs_held = 0;
  logic [sssp_pkg::VCOUNT_W-1:0] vcount_reg = 5'd1;
  longint                        cost_tbl [MAX_NODES];
  logic [sssp_pkg::VIDX_W-1:0]   prev_tbl [MAX_NODES];
  logic [MAX_NODES-1:0]          seen_mask;
  path_word_t                    paths_due [$];
  int                            fault_count = 0;
  int                            items_sent = 0;
  int                            idle_cycles = 0;
  bit                            gaps_on = 1'b1;

  single_source_shortest_path_top #(
    .MAX_VERTICES(MAX_NODES),
    .MAX_EDGES(MAX_ARCS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req_type(in_req_type),
    .in_edge_from(in_edge_from),
    .in_edge_to(in_edge_to),
    .in_edge_weight(in_edge_weight),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_strobe(out_strobe),
    .out_vertex_index(out_vertex_index),
    .out_distance(out_distance),
    .out_predecessor(out_predecessor),
    .out_reachable(out_reachable),
    .out_negative_cycle(out_negative_cycle),
    .out_last(out_last)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int active_count();
    if (vcount_reg == 0) return 1;
    if (vcount_reg > MAX_NODES) return MAX_NODES;
    return int'(vcount_reg);
  endfunction

  function automatic bit can_lower(input sssp_pkg::edge_t a, input int n);
    if (a.src >= n || a.dst >= n) return 1'b0;
    if (!seen_mask[a.src]) return 1'b0;
    if (!seen_mask[a.dst]) return 1'b1;
    return cost_tbl[a.src] + longint'(a.weight) < cost_tbl[a.dst];
  endfunction

  function automatic void solve_paths();
    int         n;
    bit         looped;
    longint     c;
    path_word_t w;
    n = active_count();
    looped = 1'b0;
    for (int v = 0; v < n; v++) begin
      cost_tbl[v] = 0;
      prev_tbl[v] = '0;
    end
    seen_mask = 16'h0001;
    for (int pass = 0; pass < n; pass++) begin
      for (int j = 0; j < arcs_held; j++) begin
        if (can_lower(arc_store[j], n)) begin
          cost_tbl[arc_store[j].dst] = cost_tbl[arc_store[j].src] + longint'(arc_store[j].weight);
          prev_tbl[arc_store[j].dst] = arc_store[j].src;
          seen_mask[arc_store[j].dst] = 1'b1;
        end
      end
    end
    for (int j = 0; j < arcs_held; j++) begin
      if (can_lower(arc_store[j], n)) looped = 1'b1;
    end
    arcs_held = 0;
    if (looped) begin
      paths_due.push_back('{vertex: '0, span: '0, prev: '0, reach: 1'b0, neg: 1'b1, last: 1'b1});
    end else begin
      for (int v = 0; v < n; v++) begin
        c = cost_tbl[v];
        if (c > sssp_pkg::DIST_MAX) c = sssp_pkg::DIST_MAX;
        if (c < sssp_pkg::DIST_MIN) c = sssp_pkg::DIST_MIN;
        w.vertex = v[3:0];
        w.span   = seen_mask[v] ? c[20:0] : '0;
        w.prev   = seen_mask[v] ? prev_tbl[v] : '0;
        w.reach  = seen_mask[v];
        w.neg    = 1'b0;
        w.last   = (v + 1 == n);
        paths_due.push_back(w);
      end
    end
  endfunction

  function automatic void log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  // Result words are checked in order against the oldest expected word.
  always @(posedge clk) begin
    path_word_t got;
    path_word_t want;
    if (rst_n && out_strobe) begin
      got = '{vertex: out_vertex_index, span: out_distance, prev: out_predecessor,
              reach: out_reachable, neg: out_negative_cycle, last: out_last};
      if (paths_due.size() == 0) begin
        log_fault($sformatf("unexpected word: vertex %0d dist %0d pred %0d reach %b neg %b last %b",
                            got.vertex, got.span, got.prev, got.reach, got.neg, got.last));
      end else begin
        want = paths_due.pop_front();
        if (got !== want) begin
          log_fault($sformatf({"mismatch: got vertex %0d dist %0d pred %0d reach %b neg %b last %b,",
                               " expected vertex %0d dist %0d pred %0d reach %b neg %b last %b"},
                              got.vertex, got.span, got.prev, got.reach, got.neg, got.last,
                              want.vertex, want.span, want.prev, want.reach, want.neg, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL single_source_shortest_path_top");
        $finish;
      end
    end
  end

  task automatic send_word(input logic req, input logic [3:0] from_v, input logic [3:0] to_v,
                           input logic signed [15:0] wt);
    while (gaps_on && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_req_type    <= req;
    in_edge_from   <= from_v;
    in_edge_to     <= to_v;
    in_edge_weight <= wt;
    do @(posedge clk); while (busy);
    if (req == sssp_pkg::REQ_LOAD) begin
      if (arcs_held < MAX_ARCS) begin
        arc_store[arcs_held] = '{src: from_v, dst: to_v, weight: wt};
        arcs_held++;
      end
    end else begin
      solve_paths();
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_search();
    send_word(sssp_pkg::REQ_START, 4'($urandom), 4'($urandom), 16'($urandom));
  endtask

  task automatic write_vcount(input logic [4:0] val);
    start <= 1'b0;
    wait (paths_due.size() == 0);
    do @(posedge clk); while (busy);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    vcount_reg = val;
  endtask

  task automatic test_reset_defaults();
    send_search();
  endtask

  task automatic test_vcount_zero();
    write_vcount(5'd0);
    send_word(sssp_pkg::REQ_LOAD, 4'd0, 4'd1, 16'sd5);
    send_search();
  endtask

  task automatic test_weight_extremes();
    write_vcount(5'd16);
    send_word(sssp_pkg::REQ_LOAD, 4'd0, 4'd15, 16'sd32767);
    send_word(sssp_pkg::REQ_LOAD, 4'd15, 4'd14, 16'sd32767);
    send_word(sssp_pkg::REQ_LOAD, 4'd0, 4'd1, -16'sd32768);
    send_word(sssp_pkg::REQ_LOAD, 4'd1, 4'd2, -16'sd32768);
    send_word(sssp_pkg::REQ_LOAD, 4'd3, 4'd3, 16'sd0);
    send_search();
  endtask

  task automatic test_unreachable_vertices();
    write_vcount(5'd5);
    send_word(sssp_pkg::REQ_LOAD, 4'd0, 4'd1, 16'sd3);
    send_word(sssp_pkg::REQ_LOAD, 4'd1, 4'd9, 16'sd2);
    send_word(sssp_pkg::REQ_LOAD, 4'd12, 4'd2, 16'sd1);
    send_word(sssp_pkg::REQ_LOAD, 4'd1, 4'd2, 16'sd4);
    send_word(sssp_pkg::REQ_LOAD, 4'd3, 4'd4, -16'sd5);
    send_word(sssp_pkg::REQ_LOAD, 4'd4, 4'd3, -16'sd5);
    send_search();
  endtask

  task automatic test_negative_cycle();
    write_vcount(5'd3);
    send_word(sssp_pkg::REQ_LOAD, 4'd0, 4'd1, 16'sd2);
    send_word(sssp_pkg::REQ_LOAD, 4'd1, 4'd2, -16'sd3);
    send_word(sssp_pkg::REQ_LOAD, 4'd2, 4'd1, 16'sd1);
    send_search();
  endtask

  task automatic test_vcount_saturation();
    write_vcount(5'd31);
    send_word(sssp_pkg::REQ_LOAD, 4'd0, 4'd15, 16'sd7);
    send_search();
  endtask

  task automatic test_full_edge_store();
    gaps_on = 1'b0;
    write_vcount(5'd8);
    repeat (MAX_ARCS + 6) begin
      send_word(sssp_pkg::REQ_LOAD, 4'($urandom), 4'($urandom), 16'($urandom_range(0, 1000)));
    end
    send_search();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_graphs();
    int                 sel;
    int                 n_eff;
    logic [3:0]         a;
    logic [3:0]         b;
    logic signed [15:0] w;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) != 0) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) write_vcount(5'd0);
        else if (sel == 1) write_vcount(5'd16);
        else if (sel == 2) write_vcount(5'($urandom_range(17, 31)));
        else write_vcount(5'($urandom_range(1, 8)));
      end
      n_eff = active_count();
      repeat ($urandom_range(0, 12)) begin
        a = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n_eff - 1));
        b = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, n_eff - 1));
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          w = 16'($urandom_range(0, 200));
        end else if (sel < 85) begin
          w = 16'($urandom_range(1, 60));
          w = -w;
        end else begin
          w = 16'($urandom);
        end
        send_word(sssp_pkg::REQ_LOAD, a, b, w);
      end
      send_search();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_vcount_zero();
    test_weight_extremes();
    test_unreachable_vertices();
    test_negative_cycle();
    test_vcount_saturation();
    test_full_edge_store();
    test_random_graphs();
    start <= 1'b0;
    wait (paths_due.size() == 0);
    repeat (20) @(posedge clk);
    if (fault_count == 0 && paths_due.size() == 0) begin
      $display("PASS single_source_shortest_path_top");
    end else begin
      $display("FAIL single_source_shortest_path_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sssp_pkg.sv
rtl/sssp_ram.sv
rtl/sssp_relax.sv
rtl/single_source_shortest_path_top.sv
dv/single_source_shortest_path_top_tb.sv
